FILE: rtl/spid_pkg.sv
// Package for the staged incremental PID unit: field widths, register codes,
// stage codes and the gain bundle shared by the top level and the increment pipe.
// Depends on nothing.
`default_nettype none

package spid_pkg;

    localparam int SAMPLE_W   = 16;   // setpoint and measured samples
    localparam int ERR_W      = 17;   // error = setpoint - measured
    localparam int GAIN_W     = 27;   // Q16 gains
    localparam int COEF_W     = 29;   // sum of up to three gains, or P + 2D
    localparam int PROD_W     = COEF_W + ERR_W;
    localparam int DELTA_W    = PROD_W + 2;
    localparam int DRIVE_W    = 31;   // Q16 control value and clamp limits
    localparam int SUM_W      = DELTA_W + 1;
    localparam int CMP_W      = SAMPLE_W + 6;  // room for 20 * sample
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DRIVE_W;

    // Scale factors of the stage tests: 20*ms < 13*sp and 5*ms < 4*sp.
    localparam logic signed [CMP_W-1:0] LOW_MS_MUL = CMP_W'(20);
    localparam logic signed [CMP_W-1:0] LOW_SP_MUL = CMP_W'(13);
    localparam logic signed [CMP_W-1:0] MID_MS_MUL = CMP_W'(5);
    localparam logic signed [CMP_W-1:0] MID_SP_MUL = CMP_W'(4);

    localparam logic signed [DRIVE_W-1:0] OUT_MIN_RST = -DRIVE_W'(655360000);
    localparam logic signed [DRIVE_W-1:0] OUT_MAX_RST = DRIVE_W'(655360000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_PROP  = 3'd0,
        CFG_GAIN_INTEG = 3'd1,
        CFG_GAIN_DERIV = 3'd2,
        CFG_OUT_MIN    = 3'd3,
        CFG_OUT_MAX    = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        STAGE_INTEG = 2'd0,
        STAGE_PI    = 2'd1,
        STAGE_PID   = 2'd2
    } t_stage;

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop;
        logic signed [GAIN_W-1:0] integ;
        logic signed [GAIN_W-1:0] deriv;
    } t_gains;

    // Load enables of the three increment stages, driven by the top level.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } t_pipe_ld;

endpackage

`default_nettype wire

FILE: rtl/spid_incr.sv
// Increment pipeline: error and stage choice, three gain products, their sum.
// Also keeps the two-deep error history. Depends on spid_pkg.
`default_nettype none

module spid_incr (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire spid_pkg::t_pipe_ld                     i_ld,
    input  wire spid_pkg::t_gains                       i_gains,
    input  wire logic signed [spid_pkg::SAMPLE_W-1:0]   i_setpoint,
    input  wire logic signed [spid_pkg::SAMPLE_W-1:0]   i_measured,
    output logic signed [spid_pkg::DELTA_W-1:0]         o_delta
);

    // Stage 1 combinational terms.
    logic signed [spid_pkg::ERR_W-1:0]  w_err;
    logic signed [spid_pkg::CMP_W-1:0]  w_ms_low, w_sp_low, w_ms_mid, w_sp_mid;
    spid_pkg::t_stage                   w_stage;
    logic signed [spid_pkg::COEF_W-1:0] w_p, w_i, w_d;
    logic signed [spid_pkg::COEF_W-1:0] n_coef_a, n_coef_b, n_coef_c;

    // Error history (reset to zero) and stage registers.
    logic signed [spid_pkg::ERR_W-1:0]  r_hist1, r_hist2;
    logic signed [spid_pkg::ERR_W-1:0]  r_e, r_e1, r_e2;
    logic signed [spid_pkg::COEF_W-1:0] r_coef_a, r_coef_b, r_coef_c;
    logic signed [spid_pkg::PROD_W-1:0] r_prod_a, r_prod_b, r_prod_c;
    logic signed [spid_pkg::DELTA_W-1:0] r_delta;

    assign w_err = spid_pkg::ERR_W'(i_setpoint) - spid_pkg::ERR_W'(i_measured);

    assign w_ms_low = spid_pkg::CMP_W'(i_measured) * spid_pkg::LOW_MS_MUL;
    assign w_sp_low = spid_pkg::CMP_W'(i_setpoint) * spid_pkg::LOW_SP_MUL;
    assign w_ms_mid = spid_pkg::CMP_W'(i_measured) * spid_pkg::MID_MS_MUL;
    assign w_sp_mid = spid_pkg::CMP_W'(i_setpoint) * spid_pkg::MID_SP_MUL;

    always_comb begin
        priority if (w_ms_low < w_sp_low) begin
            w_stage = spid_pkg::STAGE_INTEG;
        end else if (w_ms_mid < w_sp_mid) begin
            w_stage = spid_pkg::STAGE_PI;
        end else begin
            w_stage = spid_pkg::STAGE_PID;
        end
    end

    assign w_p = spid_pkg::COEF_W'(i_gains.prop);
    assign w_i = spid_pkg::COEF_W'(i_gains.integ);
    assign w_d = spid_pkg::COEF_W'(i_gains.deriv);

    // The increment is coef_a*e - coef_b*e1 + coef_c*e2 in every stage.
    always_comb begin
        unique case (w_stage)
            spid_pkg::STAGE_INTEG: begin
                n_coef_a = w_i;
                n_coef_b = '0;
                n_coef_c = '0;
            end
            spid_pkg::STAGE_PI: begin
                n_coef_a = w_i + w_p;
                n_coef_b = w_p;
                n_coef_c = '0;
            end
            default: begin
                n_coef_a = w_p + w_i + w_d;
                n_coef_b = w_p + (w_d <<< 1);
                n_coef_c = w_d;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist1 <= '0;
            r_hist2 <= '0;
        end else if (i_ld.ld1) begin
            r_hist1 <= w_err;
            r_hist2 <= r_hist1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.ld1) begin
            r_e      <= w_err;
            r_e1     <= r_hist1;
            r_e2     <= r_hist2;
            r_coef_a <= n_coef_a;
            r_coef_b <= n_coef_b;
            r_coef_c <= n_coef_c;
        end
        if (i_ld.ld2) begin
            r_prod_a <= spid_pkg::PROD_W'(r_coef_a) * spid_pkg::PROD_W'(r_e);
            r_prod_b <= spid_pkg::PROD_W'(r_coef_b) * spid_pkg::PROD_W'(r_e1);
            r_prod_c <= spid_pkg::PROD_W'(r_coef_c) * spid_pkg::PROD_W'(r_e2);
        end
        if (i_ld.ld3) begin
            r_delta <= spid_pkg::DELTA_W'(r_prod_a) - spid_pkg::DELTA_W'(r_prod_b)
                     + spid_pkg::DELTA_W'(r_prod_c);
        end
    end

    assign o_delta = r_delta;

endmodule

`default_nettype wire

FILE: rtl/staged_incremental_pid_unit.sv
// Top level of the staged incremental PID unit; uses spid_pkg and spid_incr.
// A word passes the input register, the increment stages and the output register in turn.
// Throughput: one word per cycle while the output is taken; the only feedback loop is the
// accumulate-and-clamp of the control value, every other stage is a plain pipe.
// Reset (synchronous, active low): pipe empty, history and control value zero, defaults loaded.
`default_nettype none

module staged_incremental_pid_unit (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    // Configuration write port.
    input  wire logic                                     i_cfg_we,
    input  wire logic [spid_pkg::CFG_IDX_W-1:0]           i_cfg_idx,
    input  wire logic [spid_pkg::CFG_DATA_W-1:0]          i_cfg_data,
    // Input word channel.
    input  wire logic                                     i_valid,
    output logic                                          o_ready,
    input  wire logic signed [spid_pkg::SAMPLE_W-1:0]     i_setpoint,
    input  wire logic signed [spid_pkg::SAMPLE_W-1:0]     i_measured,
    // Output word channel.
    output logic                                          o_valid,
    input  wire logic                                     i_ready,
    output logic signed [spid_pkg::DRIVE_W-1:0]           o_drive
);

    // Configuration registers.
    spid_pkg::t_gains                     r_gains;
    logic signed [spid_pkg::DRIVE_W-1:0]  r_out_min, r_out_max;

    // Pipe occupancy. Stage 0 is the input register, stages 1 to 3 live in
    // spid_incr, stage 4 is the output register that holds the control value.
    logic r_v0, r_v1, r_v2, r_v3, r_v4;
    logic w_free0, w_free1, w_free2, w_free3;
    logic w_acc_in, w_ld4;
    spid_pkg::t_pipe_ld w_ld;

    logic signed [spid_pkg::SAMPLE_W-1:0] r_setpoint, r_measured;
    logic signed [spid_pkg::DELTA_W-1:0]  w_delta;

    logic signed [spid_pkg::DRIVE_W-1:0]  r_accum, n_accum;
    logic signed [spid_pkg::SUM_W-1:0]    w_sum, w_raised, w_lowered;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains   <= '0;
            r_out_min <= spid_pkg::OUT_MIN_RST;
            r_out_max <= spid_pkg::OUT_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (spid_pkg::t_cfg_idx'(i_cfg_idx))
                spid_pkg::CFG_GAIN_PROP:  r_gains.prop  <= i_cfg_data[spid_pkg::GAIN_W-1:0];
                spid_pkg::CFG_GAIN_INTEG: r_gains.integ <= i_cfg_data[spid_pkg::GAIN_W-1:0];
                spid_pkg::CFG_GAIN_DERIV: r_gains.deriv <= i_cfg_data[spid_pkg::GAIN_W-1:0];
                spid_pkg::CFG_OUT_MIN:    r_out_min     <= i_cfg_data;
                spid_pkg::CFG_OUT_MAX:    r_out_max     <= i_cfg_data;
                default: begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    // Each stage loads when it holds a word and the next stage is empty or
    // is handing its word on in the same cycle. The ready chain runs from the
    // output back to the input, so bubbles close up and the input keeps
    // accepting words while a finished result waits to be taken, until every stage is full.
    assign w_ld4   = r_v3 && (!r_v4 || i_ready);
    assign w_free3 = !r_v3 || w_ld4;
    assign w_ld.ld3 = r_v2 && w_free3;
    assign w_free2 = !r_v2 || w_ld.ld3;
    assign w_ld.ld2 = r_v1 && w_free2;
    assign w_free1 = !r_v1 || w_ld.ld2;
    assign w_ld.ld1 = r_v0 && w_free1;
    assign w_free0 = !r_v0 || w_ld.ld1;

    assign o_ready  = w_free0;
    assign w_acc_in = i_valid && w_free0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v0 <= w_acc_in || (r_v0 && !w_ld.ld1);
            r_v1 <= w_ld.ld1 || (r_v1 && !w_ld.ld2);
            r_v2 <= w_ld.ld2 || (r_v2 && !w_ld.ld3);
            r_v3 <= w_ld.ld3 || (r_v3 && !w_ld4);
            r_v4 <= w_ld4    || (r_v4 && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_setpoint <= i_setpoint;
            r_measured <= i_measured;
        end
    end

    spid_incr u_incr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ld       (w_ld),
        .i_gains    (r_gains),
        .i_setpoint (r_setpoint),
        .i_measured (r_measured),
        .o_delta    (w_delta)
    );

    // Accumulate and clamp. The lower bound is applied first and the upper
    // bound last, so crossed limits give the upper bound.
    always_comb begin
        w_sum     = spid_pkg::SUM_W'(r_accum) + spid_pkg::SUM_W'(w_delta);
        w_raised  = (w_sum < spid_pkg::SUM_W'(r_out_min))
                  ? spid_pkg::SUM_W'(r_out_min) : w_sum;
        w_lowered = (w_raised > spid_pkg::SUM_W'(r_out_max))
                  ? spid_pkg::SUM_W'(r_out_max) : w_raised;
        n_accum   = w_lowered[spid_pkg::DRIVE_W-1:0];
    end

    // The control value doubles as the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
        end else if (w_ld4) begin
            r_accum <= n_accum;
        end
    end

    assign o_valid = r_v4;
    assign o_drive = r_accum;

`ifndef ASSERT_OFF
    a_clamp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ld4 && (r_out_min <= r_out_max)) |=>
        ((r_accum >= $past(r_out_min)) && (r_accum <= $past(r_out_max))))
        else $error("control value left the clamp range");

    a_accum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_ld4 |=> $stable(r_accum))
        else $error("control value changed without a word reaching the output");

    a_input_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_in |=> r_v0)
        else $error("accepted word not held in the input stage");

    a_output_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && i_ready && !w_ld4) |=> !o_valid)
        else $error("output word repeated after it was taken");
`endif

endmodule

`default_nettype wire
